// ===== hw/rtl/identity_frame_stream_matcher_assert.svh =====
// assertion macros shared by the checker of the identity frame matcher
// no dependencies; include once per compilation unit
`ifndef IDENTITY_FRAME_STREAM_MATCHER_ASSERT_SVH
`define IDENTITY_FRAME_STREAM_MATCHER_ASSERT_SVH

// same-cycle implication, quiet while reset is held
`define IFSM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, quiet while reset is held
`define IFSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== hw/rtl/ifsm_pkg.sv =====
// shared constants, types and pattern tables of the identity frame matcher
// no dependencies
`default_nettype none

package ifsm_pkg;

	localparam int unsigned FRAME_BYTES = 35;
	localparam int unsigned FILL_W      = $clog2(FRAME_BYTES + 1);
	localparam int unsigned SEQ_W       = 32;

	localparam logic [7:0] HDR_MAGIC   = 8'ha5;
	localparam logic [7:0] HDR_TYPE    = 8'h06;
	localparam logic [7:0] HDR_ONE     = 8'h01;
	localparam logic [7:0] HDR_SPACE   = 8'h20;
	localparam logic [7:0] BYTE_ZERO   = 8'h00;
	localparam logic [7:0] PRINT_LOW   = 8'd33;
	localparam logic [7:0] PRINT_HIGH  = 8'd126;

	typedef enum logic [1:0] {
		CK_FREE,
		CK_EXACT,
		CK_PRINT,
		CK_ZERO
	} cell_kind_t;

	// per-transfer decision of the sequence tracker
	typedef struct packed {
		logic take;
		logic drop;
		logic full;
	} seq_ctl_t;

	function automatic cell_kind_t cell_kind(input int unsigned idx);
		cell_kind_t k;
		if (idx <= 4 || idx == 9 || idx == 10) begin
			k = CK_EXACT;
		end else if (idx <= 8) begin
			k = CK_FREE;
		end else if (idx <= 22) begin
			k = CK_PRINT;
		end else if (idx <= 26) begin
			k = CK_ZERO;
		end else if (idx <= 34) begin
			k = CK_PRINT;
		end else begin
			k = CK_ZERO;
		end
		return k;
	endfunction

	function automatic logic [7:0] cell_expect(input int unsigned idx);
		logic [7:0] v;
		case (idx)
			0:       v = HDR_MAGIC;
			1:       v = HDR_TYPE;
			2, 3:    v = HDR_ONE;
			10:      v = HDR_SPACE;
			default: v = BYTE_ZERO;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ifsm_cell.sv =====
// one window byte: holds it, passes it to the older neighbor, checks it
// depends on ifsm_pkg
`default_nettype none

module ifsm_cell
	import ifsm_pkg::*;
(
	input  wire logic       clk,
	input  wire cell_kind_t kind,
	input  wire logic [7:0] expect_byte,
	input  wire logic       shift_en,
	input  wire logic [7:0] byte_in,
	output logic [7:0]      byte_q,
	output logic            ok_q
);

	logic [7:0] nxt;
	logic       ok_nxt;

	assign nxt = shift_en ? byte_in : byte_q;

	// check is taken on the value the cell will hold after this edge
	always_comb begin
		case (kind)
			CK_FREE:  ok_nxt = 1'b1;
			CK_EXACT: ok_nxt = (nxt == expect_byte);
			CK_PRINT: ok_nxt = nxt inside {[PRINT_LOW:PRINT_HIGH]};
			CK_ZERO:  ok_nxt = (nxt == BYTE_ZERO);
			default:  ok_nxt = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		byte_q <= nxt;
		ok_q   <= ok_nxt;
	end

endmodule

`default_nettype wire

// ===== hw/rtl/ifsm_seq_track.sv =====
// sequence tracking: duplicate drop, gap restart and window fill count
// depends on ifsm_pkg
`default_nettype none

module ifsm_seq_track
	import ifsm_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             accept,
	input  wire logic [SEQ_W-1:0] byte_seq,
	output seq_ctl_t              ctl
);

	logic             active_q;
	logic [SEQ_W-1:0] expected_q;
	logic [FILL_W-1:0] fill_q;
	logic [SEQ_W-1:0] diff;
	logic [FILL_W-1:0] fill_base;
	logic [FILL_W-1:0] fill_nxt;

	assign diff = byte_seq - expected_q;

	always_comb begin
		ctl.drop  = active_q && diff[SEQ_W-1];
		ctl.take  = accept && !ctl.drop;
		// a gap restarts the fill count before the byte goes in
		fill_base = (active_q && (diff != '0)) ? '0 : fill_q;
		fill_nxt  = (fill_base >= FILL_W'(FRAME_BYTES)) ? FILL_W'(FRAME_BYTES)
		                                                 : fill_base + 1'b1;
		ctl.full  = ctl.take && (fill_nxt == FILL_W'(FRAME_BYTES));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= 1'b0;
			expected_q <= '0;
			fill_q     <= '0;
		end else if (ctl.take) begin
			active_q   <= 1'b1;
			expected_q <= byte_seq + 1'b1;
			fill_q     <= fill_nxt;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/identity_frame_stream_matcher.sv =====
// Identity frame stream matcher.
// Input channel: data_byte, byte_seq, segment_end with in_valid / in_stall.
// Output channel: byte_dropped, match, segment_found, serial_high, serial_low,
// frame_key with out_valid / out_stall. One result per input transfer.
// A transfer is taken at an edge with valid high and stall low.
// The result of a transfer is held in the middle stage (valid_s1) and then
// registered on the output; the middle stage holds while the output is stalled.
// Throughput: one byte per cycle; a new byte is taken every cycle while the
// output is not stalled. The window is a chain of byte cells that shift by one
// on each kept byte and check their own byte as it goes in; the match is the
// AND of the registered cell checks.
// Duplicates (negative sequence difference) leave the window untouched; a gap
// restarts the fill count.
// Reset clears the sequence state, fill count, segment flag and both valids;
// window bytes are not cleared and are only checked once the window is full.
// When the receiver stalls, the output holds; in_stall rises as soon as the
// middle stage holds a byte as well, so at most one more byte is taken.
// depends on ifsm_pkg, ifsm_cell, ifsm_seq_track
`default_nettype none

module identity_frame_stream_matcher
	import ifsm_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [7:0]       data_byte,
	input  wire logic [SEQ_W-1:0] byte_seq,
	input  wire logic             segment_end,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic                  byte_dropped,
	output logic                  match,
	output logic                  segment_found,
	output logic [63:0]           serial_high,
	output logic [31:0]           serial_low,
	output logic [63:0]           frame_key
);

	logic     accept;
	seq_ctl_t ctl;

	logic [7:0]             win [FRAME_BYTES];
	logic [FRAME_BYTES-1:0] ok;

	logic valid_s1, drop_s1, full_s1, seg_end_s1;
	logic s1_go;
	logic hit;
	logic found_q;

	logic        out_valid_q;
	logic        dropped_q, match_q, found_out_q;
	logic [63:0] serial_high_q, frame_key_q;
	logic [31:0] serial_low_q;
	logic [63:0] ser_hi_w, key_w;
	logic [31:0] ser_lo_w;

	assign s1_go    = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !s1_go;
	assign accept   = in_valid && !in_stall;

	ifsm_seq_track u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.byte_seq (byte_seq),
		.ctl      (ctl)
	);

	// newest byte enters the top cell, cell 0 holds the oldest
	for (genvar i = 0; i < FRAME_BYTES; i++) begin : g_cell
		logic [7:0] feed;
		if (i == FRAME_BYTES - 1) begin : g_top
			assign feed = data_byte;
		end else begin : g_mid
			assign feed = win[i+1];
		end
		ifsm_cell u_cell (
			.clk         (clk),
			.kind        (cell_kind(i)),
			.expect_byte (cell_expect(i)),
			.shift_en    (ctl.take),
			.byte_in     (feed),
			.byte_q      (win[i]),
			.ok_q        (ok[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			drop_s1    <= ctl.drop;
			full_s1    <= ctl.full;
			seg_end_s1 <= segment_end;
		end
	end

	assign hit = full_s1 && (&ok);

	always_comb begin
		for (int k = 0; k < 8; k++) begin
			ser_hi_w[63-8*k -: 8] = win[11+k];
			key_w[63-8*k -: 8]    = win[27+k];
		end
		for (int k = 0; k < 4; k++) begin
			ser_lo_w[31-8*k -: 8] = win[19+k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_go) begin
				found_q     <= seg_end_s1 ? 1'b0 : (found_q || hit);
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			dropped_q     <= drop_s1;
			match_q       <= hit;
			found_out_q   <= found_q || hit;
			serial_high_q <= hit ? ser_hi_w : '0;
			serial_low_q  <= hit ? ser_lo_w : '0;
			frame_key_q   <= hit ? key_w : '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign byte_dropped  = dropped_q;
	assign match         = match_q;
	assign segment_found = found_out_q;
	assign serial_high   = serial_high_q;
	assign serial_low    = serial_low_q;
	assign frame_key     = frame_key_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ifsm_checker.sv =====
// port-level checks of the identity frame matcher, bound to the top level
// depends on ifsm_pkg and identity_frame_stream_matcher_assert.svh
`default_nettype none
`include "identity_frame_stream_matcher_assert.svh"

module ifsm_checker
	import ifsm_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_stall,
	input wire logic             out_valid,
	input wire logic             out_stall,
	input wire logic             byte_dropped,
	input wire logic             match,
	input wire logic             segment_found,
	input wire logic [63:0]      serial_high,
	input wire logic [31:0]      serial_low,
	input wire logic [63:0]      frame_key
);

	logic payload_zero;
	assign payload_zero = (serial_high == '0) && (serial_low == '0) && (frame_key == '0);

	// fields are cleared unless the frame matched
	`IFSM_ASSERT_IMPLY(a_zero_no_match, clk, arst_n, out_valid && !match, payload_zero)
	// a dropped duplicate never completes a frame
	`IFSM_ASSERT_IMPLY(a_drop_no_match, clk, arst_n, out_valid && byte_dropped, !match)
	// segment flag covers the current match
	`IFSM_ASSERT_IMPLY(a_match_found, clk, arst_n, out_valid && match, segment_found)
	// input only backs up behind a stalled result
	`IFSM_ASSERT_IMPLY(a_stall_cause, clk, arst_n, in_stall, out_valid && out_stall)
	// a stalled result stays put
	`IFSM_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(match) && $stable(byte_dropped) && $stable(serial_high))

endmodule

bind identity_frame_stream_matcher ifsm_checker u_ifsm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.byte_dropped  (byte_dropped),
	.match         (match),
	.segment_found (segment_found),
	.serial_high   (serial_high),
	.serial_low    (serial_low),
	.frame_key     (frame_key)
);

`default_nettype wire
